// File: hw/rtl/lqm_pkg.sv
// Shared types and constants for the linked queue manager.
package lqm_pkg;

  localparam int unsigned NODES   = 16;
  localparam int unsigned QUEUES  = 4;
  localparam int unsigned NODE_W  = $clog2(NODES);
  localparam int unsigned QUEUE_W = $clog2(QUEUES);
  localparam int unsigned COUNT_W = $clog2(NODES + 1);

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [QUEUE_W-1:0] queue_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SIZE   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LINK  = 2'd1,
    ST_OWNER = 2'd2
  } status_e;

  // One write port of a link array.
  typedef struct packed {
    logic  en;
    node_t addr;
    node_t data;
  } link_wr_t;

  typedef struct packed {
    node_t  next;
    node_t  prev;
    logic   linked;
    queue_t owner;
  } node_rd_t;

  typedef struct packed {
    link_wr_t next_a;
    link_wr_t next_b;
    link_wr_t prev_a;
    link_wr_t prev_b;
    logic     link_en;
    logic     unlink_en;
    node_t    node;
    queue_t   owner;
  } node_wr_t;

  typedef struct packed {
    node_t  head;
    node_t  tail;
    count_t len;
    logic   nonempty;
  } queue_rd_t;

  typedef struct packed {
    logic   en;
    queue_t addr;
    node_t  head;
    node_t  tail;
    count_t len;
    logic   nonempty;
  } queue_wr_t;

endpackage

// File: hw/rtl/linked_queue_manager_top.sv
// Top level of the linked queue manager: input register, tables and result register.
//
// A pool of 16 nodes is linked into 4 circular doubly linked queues.
// Command channel: drive operation_i, queue_id_i and node_id_i with start;
// an item is taken at each rising edge where start is high and busy is low.
// busy stays low, so a new item may be started in every cycle.
// Operations: append a node at a queue's tail, remove a node from its
// queue, or report a queue's size (unused codes report size as well).
// Each item gives exactly one result on status_o, queue_count_o,
// head_node_o and head_valid_o, marked by done_o for one cycle.
// Each item is held in the input register, then passes through the link and
// queue tables into the result register. Throughput is one item per cycle;
// the next item sees all state the previous one left.
// Reset empties every queue and unlinks every node; it is asynchronous.
// The receiver cannot stall: each result must be taken in its done_o cycle.
module linked_queue_manager_top import lqm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] operation_i,
  input  logic [1:0] queue_id_i,
  input  logic [3:0] node_id_i,
  output logic       done_o,
  output logic [1:0] status_o,
  output logic [4:0] queue_count_o,
  output logic [3:0] head_node_o,
  output logic       head_valid_o
);

  logic   item_v_q;
  op_e    op_q;
  queue_t queue_q;
  node_t  node_q;

  node_rd_t  node_rd;
  node_wr_t  node_wr;
  queue_rd_t queue_rd;
  queue_wr_t queue_wr;

  status_e status_d;
  count_t  count_d;
  node_t   head_d;
  logic    head_valid_d;

  logic    done_q;
  status_e status_q;
  count_t  count_q;
  node_t   head_q;
  logic    head_valid_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      item_v_q <= start && !busy;
      done_q   <= item_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      op_q    <= op_e'(operation_i);
      queue_q <= queue_t'(queue_id_i);
      node_q  <= node_t'(node_id_i);
    end
    if (item_v_q) begin
      status_q     <= status_d;
      count_q      <= count_d;
      head_q       <= head_d;
      head_valid_q <= head_valid_d;
    end
  end

  lqm_node_table u_node_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (node_q),
    .rd_o      (node_rd),
    .wr_i      (node_wr)
  );

  lqm_queue_table u_queue_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (queue_q),
    .rd_o      (queue_rd),
    .wr_i      (queue_wr)
  );

  lqm_ctrl u_ctrl (
    .valid_i      (item_v_q),
    .op_i         (op_q),
    .queue_i      (queue_q),
    .node_i       (node_q),
    .node_rd_i    (node_rd),
    .queue_rd_i   (queue_rd),
    .node_wr_o    (node_wr),
    .queue_wr_o   (queue_wr),
    .status_o     (status_d),
    .count_o      (count_d),
    .head_o       (head_d),
    .head_valid_o (head_valid_d)
  );

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign queue_count_o = count_q;
  assign head_node_o   = head_q;
  assign head_valid_o  = head_valid_q;

  a_done_follows_start: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (start && !busy) |-> ##2 done_o
  ) else $error("result strobe missing two cycles after start");

  a_empty_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (done_o && !head_valid_o) |-> (queue_count_o == '0 && head_node_o == '0)
  ) else $error("empty queue reported with nonzero count or head");

  a_nonempty_count: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (done_o && head_valid_o) |-> (queue_count_o != '0)
  ) else $error("nonempty queue reported with zero count");

  a_no_double_link: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      !(node_wr.link_en && node_wr.unlink_en)
  ) else $error("node linked and unlinked in one cycle");

endmodule

// File: hw/rtl/lqm_node_table.sv
// Per-node ring links, linked flags and owner tags.
module lqm_node_table import lqm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  node_t    rd_addr_i,
  output node_rd_t rd_o,
  input  node_wr_t wr_i
);

  node_t  next_q   [NODES];
  node_t  prev_q   [NODES];
  queue_t owner_q  [NODES];
  logic   linked_q [NODES];

  assign rd_o.next   = next_q[rd_addr_i];
  assign rd_o.prev   = prev_q[rd_addr_i];
  assign rd_o.linked = linked_q[rd_addr_i];
  assign rd_o.owner  = owner_q[rd_addr_i];

  // Links and owners are only read for linked nodes, so they need no reset.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NODES; i++) begin
      if (wr_i.next_a.en && wr_i.next_a.addr == node_t'(i)) begin
        next_q[i] <= wr_i.next_a.data;
      end else if (wr_i.next_b.en && wr_i.next_b.addr == node_t'(i)) begin
        next_q[i] <= wr_i.next_b.data;
      end
      if (wr_i.prev_a.en && wr_i.prev_a.addr == node_t'(i)) begin
        prev_q[i] <= wr_i.prev_a.data;
      end else if (wr_i.prev_b.en && wr_i.prev_b.addr == node_t'(i)) begin
        prev_q[i] <= wr_i.prev_b.data;
      end
      if (wr_i.link_en && wr_i.node == node_t'(i)) begin
        owner_q[i] <= wr_i.owner;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) begin
        linked_q[i] <= 1'b0;
      end
    end else begin
      for (int i = 0; i < NODES; i++) begin
        if (wr_i.node == node_t'(i)) begin
          if (wr_i.link_en) begin
            linked_q[i] <= 1'b1;
          end else if (wr_i.unlink_en) begin
            linked_q[i] <= 1'b0;
          end
        end
      end
    end
  end

endmodule

// File: hw/rtl/lqm_queue_table.sv
// Per-queue head, tail, length and nonempty flag.
module lqm_queue_table import lqm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  queue_t    rd_addr_i,
  output queue_rd_t rd_o,
  input  queue_wr_t wr_i
);

  node_t  head_q     [QUEUES];
  node_t  tail_q     [QUEUES];
  count_t len_q      [QUEUES];
  logic   nonempty_q [QUEUES];

  assign rd_o.head     = head_q[rd_addr_i];
  assign rd_o.tail     = tail_q[rd_addr_i];
  assign rd_o.len      = len_q[rd_addr_i];
  assign rd_o.nonempty = nonempty_q[rd_addr_i];

  // Tail is only read while the queue is nonempty.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUES; i++) begin
      if (wr_i.en && wr_i.addr == queue_t'(i)) begin
        tail_q[i] <= wr_i.tail;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUEUES; i++) begin
        head_q[i]     <= '0;
        len_q[i]      <= '0;
        nonempty_q[i] <= 1'b0;
      end
    end else begin
      for (int i = 0; i < QUEUES; i++) begin
        if (wr_i.en && wr_i.addr == queue_t'(i)) begin
          head_q[i]     <= wr_i.head;
          len_q[i]      <= wr_i.len;
          nonempty_q[i] <= wr_i.nonempty;
        end
      end
    end
  end

endmodule

// File: hw/rtl/lqm_ctrl.sv
// Decides one append, remove or size item and forms the table writes and result.
module lqm_ctrl import lqm_pkg::*; (
  input  logic      valid_i,
  input  op_e       op_i,
  input  queue_t    queue_i,
  input  node_t     node_i,
  input  node_rd_t  node_rd_i,
  input  queue_rd_t queue_rd_i,
  output node_wr_t  node_wr_o,
  output queue_wr_t queue_wr_o,
  output status_e   status_o,
  output count_t    count_o,
  output node_t     head_o,
  output logic      head_valid_o
);

  node_t p_node;
  node_t x_node;

  assign p_node = node_rd_i.prev;
  assign x_node = node_rd_i.next;

  always_comb begin
    node_wr_o           = '0;
    node_wr_o.node      = node_i;
    node_wr_o.owner     = queue_i;
    queue_wr_o.en       = 1'b0;
    queue_wr_o.addr     = queue_i;
    queue_wr_o.head     = queue_rd_i.head;
    queue_wr_o.tail     = queue_rd_i.tail;
    queue_wr_o.len      = queue_rd_i.len;
    queue_wr_o.nonempty = queue_rd_i.nonempty;
    status_o            = ST_OK;

    case (op_i)
      OP_APPEND: begin
        if (node_rd_i.linked) begin
          status_o = ST_LINK;
        end else begin
          queue_wr_o.en       = valid_i;
          node_wr_o.link_en   = valid_i;
          queue_wr_o.tail     = node_i;
          queue_wr_o.len      = queue_rd_i.len + count_t'(1);
          queue_wr_o.nonempty = 1'b1;
          if (!queue_rd_i.nonempty) begin
            // Single node rings onto itself.
            queue_wr_o.head  = node_i;
            node_wr_o.next_a = '{en: valid_i, addr: node_i, data: node_i};
            node_wr_o.prev_a = '{en: valid_i, addr: node_i, data: node_i};
          end else begin
            node_wr_o.next_a = '{en: valid_i, addr: queue_rd_i.tail, data: node_i};
            node_wr_o.next_b = '{en: valid_i, addr: node_i, data: queue_rd_i.head};
            node_wr_o.prev_a = '{en: valid_i, addr: node_i, data: queue_rd_i.tail};
            node_wr_o.prev_b = '{en: valid_i, addr: queue_rd_i.head, data: node_i};
          end
        end
      end
      OP_REMOVE: begin
        if (!queue_rd_i.nonempty || !node_rd_i.linked) begin
          status_o = ST_LINK;
        end else if (node_rd_i.owner != queue_i) begin
          status_o = ST_OWNER;
        end else begin
          queue_wr_o.en       = valid_i;
          node_wr_o.unlink_en = valid_i;
          queue_wr_o.len      = (queue_rd_i.len != '0) ?
                                queue_rd_i.len - count_t'(1) : '0;
          if (x_node == node_i) begin
            queue_wr_o.nonempty = 1'b0;
            queue_wr_o.head     = '0;
          end else begin
            if (queue_rd_i.head == node_i) begin
              queue_wr_o.head = x_node;
            end
            if (queue_rd_i.tail == node_i) begin
              queue_wr_o.tail = p_node;
            end
            // Splice the neighbors around the removed node.
            node_wr_o.next_a = '{en: valid_i, addr: p_node, data: x_node};
            node_wr_o.prev_a = '{en: valid_i, addr: x_node, data: p_node};
          end
        end
      end
      default: begin
        status_o = ST_OK;
      end
    endcase

    count_o      = queue_wr_o.len;
    head_valid_o = queue_wr_o.nonempty;
    head_o       = queue_wr_o.nonempty ? queue_wr_o.head : '0;
  end

endmodule
